>>> src/adt_pkg.sv
// ----------------------------------------------------------------------------
// adt_pkg
// Shared types, codes and constants of the atom dedup table.
// ----------------------------------------------------------------------------
package adt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;
  localparam int unsigned OPND_W = 31;
  localparam int unsigned TAG_W  = 2;
  localparam int unsigned PORT_W = 11;  // atom_index and keep_count width
  localparam int unsigned ATOM_W = TAG_W + 2 * OPND_W;
  localparam logic [TAG_W-1:0] EQ_TAG = '0;

  typedef enum logic [2:0] {
    OP_GET      = 3'd0,
    OP_FIND     = 3'd1,
    OP_GET_EQ   = 3'd2,
    OP_FIND_EQ  = 3'd3,
    OP_TRUNCATE = 3'd4,
    OP_RESET    = 3'd5,
    OP_RSVD6    = 3'd6,
    OP_RSVD7    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_KEEP  = 2'd3
  } status_t;

  // Result kinds chosen by the controller
  typedef enum logic [2:0] {
    RES_HIT,
    RES_MISS,
    RES_NEW,
    RES_FULL,
    RES_BAD_KEEP,
    RES_CLEAR_OK,
    RES_NOP
  } res_t;

  typedef struct packed {
    logic load;       // capture the input transaction
    logic rd_en;      // read the store at the scan pointer
    logic scan_inc;   // advance the scan pointer
    logic append;     // write the new atom and bump the count
    logic cnt_keep;   // truncate the count to keep_count
    logic cnt_zero;   // empty the table
    logic finish;     // load the output register
    res_t res;
  } adt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_end;   // scan pointer reached the count
    logic hit;        // stored atom equals the request
    logic full;       // count equals capacity
    logic keep_bad;   // keep_count above the count
    logic out_free;   // output register can take a result
  } adt_stat_t;

endpackage

>>> src/adt_ctrl.sv
// ----------------------------------------------------------------------------
// adt_ctrl
// Controller: sequences dispatch, store scan and result hand-off.
// ----------------------------------------------------------------------------
module adt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  adt_pkg::adt_stat_t stat,
  output adt_pkg::adt_cmd_t  cmd
);
  import adt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_READ     = 4'b0100,
    S_CMP      = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = RES_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op) inside
          OP_GET, OP_FIND, OP_GET_EQ, OP_FIND_EQ: state_next = S_READ;
          OP_TRUNCATE: begin
            if (stat.out_free) begin
              cmd.finish = 1'b1;
              if (stat.keep_bad) begin
                cmd.res = RES_BAD_KEEP;
              end else begin
                cmd.res      = RES_CLEAR_OK;
                cmd.cnt_keep = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          OP_RESET: begin
            if (stat.out_free) begin
              cmd.finish   = 1'b1;
              cmd.res      = RES_CLEAR_OK;
              cmd.cnt_zero = 1'b1;
              state_next   = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.finish = 1'b1;
              cmd.res    = RES_NOP;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        if (stat.scan_end) begin
          // Miss after the whole table: append or report
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
            if (stat.op == OP_GET || stat.op == OP_GET_EQ) begin
              if (stat.full) begin
                cmd.res = RES_FULL;
              end else begin
                cmd.res    = RES_NEW;
                cmd.append = 1'b1;
              end
            end else begin
              cmd.res = RES_MISS;
            end
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.hit) begin
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            cmd.res    = RES_HIT;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/adt_dpath.sv
// ----------------------------------------------------------------------------
// adt_dpath
// Datapath: request registers, atom store, scan pointer, count, output reg.
// ----------------------------------------------------------------------------
module adt_dpath #(
  parameter int unsigned TABLE_ENTRIES = adt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [2:0]                   operation,
  input  logic [adt_pkg::TAG_W-1:0]    atom_tag,
  input  logic [adt_pkg::OPND_W-1:0]   left_operand,
  input  logic [adt_pkg::OPND_W-1:0]   right_operand,
  input  logic [adt_pkg::PORT_W-1:0]   keep_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [adt_pkg::PORT_W-1:0] atom_index,
  output logic                         created,
  output logic [1:0]                   status,
  input  adt_pkg::adt_cmd_t            cmd,
  output adt_pkg::adt_stat_t           stat
);
  import adt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;

  logic [ATOM_W-1:0] store [TABLE_ENTRIES];
  logic [ATOM_W-1:0] rd_data;

  op_t               op;
  logic [TAG_W-1:0]  tag;
  logic [OPND_W-1:0] lft, rgt;
  logic [PORT_W-1:0] keep;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan;
  logic              is_eq, swap;

  // Normalize eq requests at capture
  assign is_eq = (op_t'(operation) == OP_GET_EQ) || (op_t'(operation) == OP_FIND_EQ);
  assign swap  = is_eq && (left_operand > right_operand);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= op_t'(operation);
      tag  <= is_eq ? EQ_TAG : atom_tag;
      lft  <= swap ? right_operand : left_operand;
      rgt  <= swap ? left_operand : right_operand;
      keep <= keep_count;
    end
  end

  // Scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + 1'b1;
    end
  end

  // Atom store: one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      store[count[IDX_W-1:0]] <= {tag, lft, rgt};
    end
    if (cmd.rd_en) begin
      rd_data <= store[scan[IDX_W-1:0]];
    end
  end

  // Atom count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_zero) begin
      count <= '0;
    end else if (cmd.cnt_keep) begin
      count <= CNT_W'(keep);
    end else if (cmd.append) begin
      count <= count + 1'b1;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.op       = op;
    stat.scan_end = (scan == count);
    stat.hit      = (rd_data == {tag, lft, rgt});
    stat.full     = (32'(count) == 32'(TABLE_ENTRIES));
    stat.keep_bad = (32'(keep) > 32'(count));
    stat.out_free = !out_valid || out_ready;
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      created    <= 1'b0;
      atom_index <= '1;
      status     <= ST_OK;
      case (cmd.res)
        RES_HIT:      atom_index <= PORT_W'(scan);
        RES_MISS:     status <= ST_NOT_FOUND;
        RES_NEW: begin
          atom_index <= PORT_W'(count);
          created    <= 1'b1;
        end
        RES_FULL:     status <= ST_FULL;
        RES_BAD_KEEP: status <= ST_BAD_KEEP;
        RES_CLEAR_OK: atom_index <= '0;
        default:      atom_index <= '1;
      endcase
    end
  end

endmodule

>>> src/atom_dedup_table.sv
// ----------------------------------------------------------------------------
// atom_dedup_table
// Hash-consing table of (tag, left, right) atoms with dense indices.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready with operation, atom_tag,
// left_operand, right_operand and keep_count; every request gives exactly
// one response on out_valid/out_ready with atom_index, created, status.
// Lookups scan the atom store from index 0 up to the current count, one
// store read and one compare per atom, so a lookup takes longer the
// higher the hit index or, on a miss, the count. Truncate, reset and unused
// codes finish in dispatch without a scan. The single-port store read
// sets the pace of the scan. One request is handled at a time.
// The response sits in an output register; the next request is accepted
// while it waits, and a finished request holds its result until the
// register frees up when the receiver stalls.
// Reset empties the table (count to zero) and clears the output register;
// no clearing pass is needed since only entries below the count are read.
// ----------------------------------------------------------------------------
module atom_dedup_table #(
  parameter int unsigned TABLE_ENTRIES = adt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 operation,
  input  logic [adt_pkg::TAG_W-1:0]  atom_tag,
  input  logic [adt_pkg::OPND_W-1:0] left_operand,
  input  logic [adt_pkg::OPND_W-1:0] right_operand,
  input  logic [adt_pkg::PORT_W-1:0] keep_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [adt_pkg::PORT_W-1:0] atom_index,
  output logic                       created,
  output logic [1:0]                 status
);
  import adt_pkg::*;

  adt_cmd_t  cmd;
  adt_stat_t stat;

  adt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  adt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .operation     (operation),
    .atom_tag      (atom_tag),
    .left_operand  (left_operand),
    .right_operand (right_operand),
    .keep_count    (keep_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .atom_index    (atom_index),
    .created       (created),
    .status        (status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

>>> tb/atom_dedup_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atom_dedup_table_tb
// Self-checking bench for the atom dedup table: a scoreboard model of the
// table predicts index, created flag and status of each transaction, a
// driver sends directed then random requests with random gaps, and a
// monitor compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module atom_dedup_table_tb;
  import adt_pkg::*;

  localparam int ENTRIES = 1024;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    op_t               op;
    logic [1:0]        tag;
    logic [OPND_W-1:0] lft;
    logic [OPND_W-1:0] rgt;
    logic [PORT_W-1:0] keep;
  } req_t;

  typedef struct packed {
    logic signed [PORT_W-1:0] idx;
    logic                     created;
    status_t                  status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic [TAG_W-1:0] atom_tag = '0;
  logic [OPND_W-1:0] left_operand = '0;
  logic [OPND_W-1:0] right_operand = '0;
  logic [PORT_W-1:0] keep_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PORT_W-1:0] atom_index;
  logic created;
  logic [1:0] status;

  atom_dedup_table dut (.*);

  // Model of the table contents
  int unsigned model_count;
  logic [1:0]        model_tag [ENTRIES];
  logic [OPND_W-1:0] model_lft [ENTRIES];
  logic [OPND_W-1:0] model_rgt [ENTRIES];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int rsp_seen = 0;
  int cycles = 0;
  int total_reqs = 0;

  function automatic rsp_t apply_request(req_t q);
    rsp_t r;
    int hit;
    logic [1:0] t;
    logic [OPND_W-1:0] a, b;
    hit = -1;
    t = q.tag;
    a = q.lft;
    b = q.rgt;
    r = '{idx: -1, created: 1'b0, status: ST_OK};
    if (q.op == OP_GET_EQ || q.op == OP_FIND_EQ) begin
      t = EQ_TAG;
      if (a > b) begin
        a = q.rgt;
        b = q.lft;
      end
    end
    if (q.op inside {OP_GET, OP_FIND, OP_GET_EQ, OP_FIND_EQ}) begin
      for (int i = 0; i < model_count; i++)
        if (hit < 0 && model_tag[i] == t && model_lft[i] == a && model_rgt[i] == b)
          hit = i;
    end
    case (q.op) inside
      OP_GET, OP_GET_EQ: begin
        if (hit >= 0) r.idx = PORT_W'(hit);
        else if (model_count >= ENTRIES) r.status = ST_FULL;
        else begin
          model_tag[model_count] = t;
          model_lft[model_count] = a;
          model_rgt[model_count] = b;
          r.idx = PORT_W'(model_count);
          r.created = 1'b1;
          model_count++;
        end
      end
      OP_FIND, OP_FIND_EQ: begin
        if (hit >= 0) r.idx = PORT_W'(hit);
        else r.status = ST_NOT_FOUND;
      end
      OP_TRUNCATE: begin
        if (q.keep > model_count) r.status = ST_BAD_KEEP;
        else begin
          model_count = 32'(q.keep);
          r.idx = 0;
        end
      end
      OP_RESET: begin
        model_count = 0;
        r.idx = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: present queued requests with random gaps
  int in_gap = 0;
  logic in_taken;
  always @(posedge clk) in_taken <= in_valid && in_ready && !rst;

  always @(negedge clk) begin
    req_t q;
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold until accepted
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        in_valid <= 1'b1;
        operation <= q.op;
        atom_tag <= q.tag;
        left_operand <= q.lft;
        right_operand <= q.rgt;
        keep_count <= q.keep;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance
  always @(posedge clk) begin
    req_t q;
    if (!rst && in_valid && in_ready) begin
      q = '{op: op_t'(operation), tag: atom_tag, lft: left_operand,
            rgt: right_operand, keep: keep_count};
      expected_rsps.push_back(apply_request(q));
    end
  end

  // Receiver stall: draw a wait after every accepted response
  int out_gap = 0;
  logic out_taken;
  always @(posedge clk) out_taken <= out_valid && out_ready && !rst;

  always @(negedge clk) begin
    int g;
    if (!rst) begin
      if (out_taken) g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      else g = out_gap;
      if (g > 0) begin
        out_ready <= 1'b0;
        out_gap <= g - 1;
      end else begin
        out_ready <= 1'b1;
        out_gap <= 0;
      end
    end
  end

  // Monitor: compare each response with the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && out_ready) begin
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        $error("response with nothing expected: index %0d", atom_index);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (atom_index !== e.idx) begin
          $error("atom_index expected %0d actual %0d", e.idx, atom_index);
          errors++;
        end
        if (created !== e.created) begin
          $error("created expected %0d actual %0d", e.created, created);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t mk(op_t op, int unsigned tag, int unsigned l,
                              int unsigned r, int unsigned keep);
    req_t q;
    q = '{op: op, tag: tag[1:0], lft: l[OPND_W-1:0], rgt: r[OPND_W-1:0],
          keep: keep[PORT_W-1:0]};
    return q;
  endfunction

  // Operand drawn from a small pool so repeats and hits are common
  function automatic int unsigned pick_opnd();
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom() & 32'h7FFF_FFFF;
      1: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: v = $urandom_range(0, 7);
    endcase
    return v;
  endfunction

  function automatic req_t rand_req(int unsigned cnt_est);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 35) return mk(OP_GET, $urandom_range(0, 3), pick_opnd(), pick_opnd(), 0);
    if (k < 55) return mk(OP_FIND, $urandom_range(0, 3), pick_opnd(), pick_opnd(), 0);
    if (k < 70) return mk(OP_GET_EQ, $urandom_range(0, 3), pick_opnd(), pick_opnd(), 0);
    if (k < 85) return mk(OP_FIND_EQ, $urandom_range(0, 3), pick_opnd(), pick_opnd(), 0);
    if (k < 93) return mk(OP_TRUNCATE, 0, pick_opnd(), pick_opnd(),
                          $urandom_range(0, cnt_est + 2));
    if (k < 95) return mk(OP_TRUNCATE, 0, 0, 0, $urandom_range(1024, 2047));
    if (k < 97) return mk(OP_RESET, $urandom_range(0, 3), pick_opnd(), pick_opnd(), 0);
    return mk(op_t'($urandom_range(6, 7)), $urandom_range(0, 3),
              pick_opnd(), pick_opnd(), $urandom_range(0, 2047));
  endfunction

  // Stimulus and end of run
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, every operation, special cases
    pending_reqs.push_back(mk(OP_FIND, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_GET, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_GET, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_reqs.push_back(mk(OP_GET, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_FIND, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    pending_reqs.push_back(mk(OP_GET_EQ, 2, 32'h5555_5555, 32'h2AAA_AAAA, 0));
    pending_reqs.push_back(mk(OP_FIND_EQ, 1, 32'h2AAA_AAAA, 32'h5555_5555, 0));
    pending_reqs.push_back(mk(OP_FIND, 0, 32'h2AAA_AAAA, 32'h5555_5555, 0));
    pending_reqs.push_back(mk(OP_FIND, 1, 5, 6, 0));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 2047));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 4));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 3));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 2));
    pending_reqs.push_back(mk(OP_FIND_EQ, 0, 32'h2AAA_AAAA, 32'h5555_5555, 0));
    pending_reqs.push_back(mk(OP_RSVD6, 3, 1, 2, 3));
    pending_reqs.push_back(mk(OP_RSVD7, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_RESET, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_FIND, 0, 0, 0, 0));
    // Fill to capacity, then hit the full case and one hit at the top entry
    for (int i = 0; i < ENTRIES; i++)
      pending_reqs.push_back(mk(OP_GET, i % 4, i, 32'h7FFF_FFFF - i, 0));
    pending_reqs.push_back(mk(OP_GET, 1, 9, 9, 0));
    pending_reqs.push_back(mk(OP_GET_EQ, 0, 9, 8, 0));
    pending_reqs.push_back(mk(OP_FIND, 3, 1023, 32'h7FFF_FFFF - 1023, 0));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 1024));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 1025));
    pending_reqs.push_back(mk(OP_TRUNCATE, 0, 0, 0, 0));
    // Random part; count estimate only steers truncate values
    for (int n = 0; n < 650; n++)
      pending_reqs.push_back(rand_req(n < 60 ? n / 2 : 30));
    total_reqs = pending_reqs.size();
    // Drain: wait for one response per request
    wait (rsp_seen >= total_reqs);
    repeat (5) @(posedge clk);
    $display("Sent every operation incl. full table, bad truncate and reserved codes;");
    $display("%0d responses checked, %0d mismatches.", rsp_seen, errors);
    if (errors == 0 && expected_rsps.size() == 0 && rsp_seen == total_reqs) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
